FILE: hdl/kalman_filter_position_velocity_macros.svh
// assertion macros for the position/velocity kalman filter
// used by the top level only, no other dependencies
`ifndef KALMAN_FILTER_POSITION_VELOCITY_MACROS_SVH
`define KALMAN_FILTER_POSITION_VELOCITY_MACROS_SVH

// same-cycle implication
`define KFPV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KFPV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/kfpv_pkg.sv
// shared types, constants and saturation helpers of the kalman filter
// no dependencies
package kfpv_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COV_FRAC      = 32;
    localparam int COV_W         = 48;
    localparam int DATA_W        = 32;
    localparam int STEP_W        = 17;
    localparam int NOISE_W       = 31;
    localparam int CFG_DATA_W    = 31;
    localparam int CFG_IDX_W     = 2;
    localparam int DIV_STEPS     = COV_W + COV_FRAC;

    localparam logic signed [COV_W-1:0] MAX48 = {1'b0, {(COV_W-1){1'b1}}};
    localparam logic signed [COV_W-1:0] MIN48 = {1'b1, {(COV_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MAX32 = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MIN32 = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_TIME   = 2'd0,
        CFG_ACCEL_NOISE = 2'd1,
        CFG_MEAS_NOISE  = 2'd2
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DT2,
        S_Q0,
        S_Q1,
        S_A,
        S_B,
        S_C,
        S_K0,
        S_K1,
        S_D,
        S_E,
        S_F,
        S_G,
        S_H,
        S_I,
        S_J,
        S_OUT
    } t_seq;

    function automatic logic signed [COV_W-1:0] sat48(input logic signed [51:0] v);
        logic signed [COV_W-1:0] r;
        if (v > 52'(MAX48)) r = MAX48;
        else if (v < 52'(MIN48)) r = MIN48;
        else r = v[COV_W-1:0];
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [49:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 50'(MAX32)) r = MAX32;
        else if (v < 50'(MIN32)) r = MIN32;
        else r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

FILE: hdl/kfpv_meas_if.sv
// measurement channel: valid/ready handshake with the position sample
// depends on kfpv_pkg
interface kfpv_meas_if;
    import kfpv_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] measurement;
    modport source (output valid, output measurement, input ready);
    modport sink (input valid, input measurement, output ready);
endinterface

FILE: hdl/kfpv_est_if.sv
// estimate channel: valid/ready handshake with position and velocity
// depends on kfpv_pkg
interface kfpv_est_if;
    import kfpv_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] position_estimate;
    logic signed [DATA_W-1:0] velocity_estimate;
    modport source (output valid, output position_estimate, output velocity_estimate,
                    input ready);
    modport sink (input valid, input position_estimate, input velocity_estimate,
                  output ready);
endinterface

FILE: hdl/kfpv_mul.sv
// bit-serial shift-add multiplier, one multiplier bit a cycle, then
// round half away from zero and saturate to 48 bits; depends on kfpv_pkg
module kfpv_mul #(
    parameter int OPW = 51
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_sh_hi,
    input  logic signed [OPW-1:0]         i_a,
    input  logic signed [OPW-1:0]         i_b,
    output logic                          o_done,
    output logic signed [kfpv_pkg::COV_W-1:0] o_res
);
    import kfpv_pkg::*;

    localparam int CW = $clog2(OPW + 1);

    logic                   r_busy, r_done, r_neg, r_hi;
    logic [CW-1:0]          r_cnt;
    logic [OPW-1:0]         r_ua;
    logic [2*OPW-1:0]       r_prod;
    logic signed [COV_W-1:0] r_res;

    logic [OPW:0]           w_sum;
    logic [2*OPW-1:0]       w_shift, w_rnd;
    logic                   w_rbit;
    logic [COV_W-1:0]       w_lim, w_mag;

    assign w_sum   = {1'b0, r_prod[2*OPW-1:OPW]} + (r_prod[0] ? {1'b0, r_ua} : '0);
    assign w_shift = r_hi ? (r_prod >> (COV_FRAC + 1)) : (r_prod >> COV_FRAC);
    assign w_rbit  = r_hi ? r_prod[COV_FRAC] : r_prod[COV_FRAC-1];
    assign w_rnd   = w_shift + (2*OPW)'(w_rbit);
    assign w_lim   = r_neg ? {1'b1, {(COV_W-1){1'b0}}} : {1'b0, {(COV_W-1){1'b1}}};
    assign w_mag   = (w_rnd > (2*OPW)'(w_lim)) ? w_lim : w_rnd[COV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(OPW);
                r_neg  <= i_a[OPW-1] ^ i_b[OPW-1];
                r_hi   <= i_sh_hi;
                r_ua   <= i_a[OPW-1] ? OPW'(-i_a) : OPW'(i_a);
                r_prod <= {{OPW{1'b0}}, (i_b[OPW-1] ? OPW'(-i_b) : OPW'(i_b))};
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_prod <= {w_sum, r_prod[OPW-1:1]};
                    r_cnt  <= r_cnt - 1'b1;
                end else begin
                    r_res  <= r_neg ? -signed'(w_mag) : signed'(w_mag);
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: hdl/kfpv_div.sv
// restoring divider, one quotient bit a cycle: num * 2^32 / den,
// truncated toward zero, saturated to 48 bits; depends on kfpv_pkg
module kfpv_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [kfpv_pkg::COV_W-1:0] i_num,
    input  logic [kfpv_pkg::COV_W:0]          i_den,
    output logic                              o_done,
    output logic signed [kfpv_pkg::COV_W-1:0] o_res
);
    import kfpv_pkg::*;

    localparam int CW = $clog2(DIV_STEPS + 1);

    logic                    r_busy, r_done, r_neg, r_ovf;
    logic [CW-1:0]           r_cnt;
    logic [COV_W-1:0]        r_dvd, r_q;
    logic [COV_W:0]          r_rem, r_den;
    logic signed [COV_W-1:0] r_res;

    logic [COV_W+1:0]        w_t, w_diff;
    logic                    w_ge;
    logic [COV_W-1:0]        w_lim, w_mag;

    assign w_t    = {r_rem, r_dvd[COV_W-1]};
    assign w_ge   = w_t >= {1'b0, r_den};
    assign w_diff = w_t - {1'b0, r_den};
    assign w_lim  = r_neg ? {1'b1, {(COV_W-1){1'b0}}} : {1'b0, {(COV_W-1){1'b1}}};
    assign w_mag  = (r_ovf || r_q > w_lim) ? w_lim : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_STEPS);
                r_neg  <= i_num[COV_W-1];
                r_dvd  <= i_num[COV_W-1] ? COV_W'(-i_num) : COV_W'(i_num);
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_rem <= w_ge ? w_diff[COV_W:0] : w_t[COV_W:0];
                    r_dvd <= {r_dvd[COV_W-2:0], 1'b0};
                    r_q   <= {r_q[COV_W-2:0], w_ge};
                    r_ovf <= r_ovf | r_q[COV_W-1];
                    r_cnt <= r_cnt - 1'b1;
                end else begin
                    r_res  <= r_neg ? -signed'(w_mag) : signed'(w_mag);
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: hdl/kalman_filter_position_velocity.sv
// top level of the two-state position/velocity kalman filter
// depends on kfpv_pkg, kfpv_meas_if, kfpv_est_if, kfpv_mul, kfpv_div and the macros header
//
// i_meas carries one position sample per transfer (signed Q16.16), o_est returns
// one position/velocity estimate per sample. i_cfg_we/i_cfg_idx/i_cfg_data write
// step time, acceleration noise and measurement noise; the user must write them
// only while the filter is idle, the block itself does not enforce it. A sample
// is taken only in the idle state; one sequencer then runs thirteen products
// through a bit-serial multiplier (OPW = 51 at 16 fractional bits) and two gains
// through a bit-serial divider; with a non-positive innovation variance the two
// divides are skipped. The sequencer returns to the idle state when it loads the
// result register, and the next sample can be accepted from there.
// The result sits in an output register, so the next sample is accepted while it
// waits; if the receiver still stalls when the next result is ready, the
// sequencer holds in its last step until the register is free.
// Synchronous reset clears the estimate, sets the covariance to identity and the
// registers to dt = 0.01, a = 20, R = 20.
`include "kalman_filter_position_velocity_macros.svh"
module kalman_filter_position_velocity #(
    parameter int FRAC_BITS = kfpv_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [kfpv_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [kfpv_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    kfpv_meas_if.sink                              i_meas,
    kfpv_est_if.source                             o_est
);
    import kfpv_pkg::*;

    localparam int UP  = COV_FRAC - FRAC_BITS;
    localparam int OPW = (32 + UP > 51) ? 32 + UP : 51;
    localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(((1 << FRAC_BITS) + 50) / 100);
    localparam logic [NOISE_W-1:0] NOISE_RST = NOISE_W'(20 << FRAC_BITS);
    localparam logic signed [OPW-1:0] ONE_OP =
        {{(OPW-COV_FRAC-1){1'b0}}, 1'b1, {COV_FRAC{1'b0}}};

    t_seq r_state, n_state;
    logic r_issued, n_issued;
    logic [STEP_W-1:0]  r_step;
    logic [NOISE_W-1:0] r_accel, r_meas;
    logic signed [DATA_W-1:0] r_pos, n_pos, r_vel, n_vel, r_xp, n_xp, r_z, n_z;
    logic signed [COV_W-1:0] r_p00, n_p00, r_p01, n_p01, r_p10, n_p10, r_p11, n_p11;
    logic signed [COV_W-1:0] r_dt2, n_dt2, r_q0, n_q0, r_q1, n_q1, r_a, n_a;
    logic signed [COV_W-1:0] r_m00, n_m00, r_m01, n_m01, r_m10, n_m10, r_m11, n_m11;
    logic signed [COV_W-1:0] r_k0, n_k0, r_k1, n_k1;
    logic r_ovalid, n_ovalid;
    logic signed [DATA_W-1:0] r_opos, n_opos, r_ovel, n_ovel;

    logic signed [OPW-1:0] w_dt, w_acc, w_one_k0, mul_a, mul_b;
    logic [OPW-1:0]        w_rv_full;
    logic signed [COV_W-1:0] w_rv, mul_res, div_res, div_num;
    logic signed [COV_W+1:0] w_s;
    logic signed [DATA_W:0]  w_innov;
    logic w_s_pos, mul_start, mul_hi, mul_done, div_start, div_done;

    assign w_dt      = signed'(OPW'(r_step) << UP);
    assign w_acc     = signed'(OPW'(r_accel) << UP);
    assign w_rv_full = OPW'(r_meas) << UP;
    assign w_rv      = (w_rv_full > OPW'(MAX48)) ? MAX48 : signed'(w_rv_full[COV_W-1:0]);
    assign w_s       = (COV_W+2)'(r_m00) + (COV_W+2)'(w_rv);
    assign w_s_pos   = !w_s[COV_W+1] && (w_s != '0);
    assign w_innov   = (DATA_W+1)'(r_z) - (DATA_W+1)'(r_xp);
    assign w_one_k0  = ONE_OP - OPW'(r_k0);
    assign div_num   = (r_state == S_K1) ? r_m10 : r_m00;

    kfpv_mul #(.OPW(OPW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_sh_hi (mul_hi),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    kfpv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (w_s[COV_W:0]),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    // multiplier operand selection
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_hi = 1'b0;
        unique case (r_state)
            S_DT2: begin mul_a = w_dt; mul_b = w_dt; end
            S_Q0: begin mul_a = OPW'(r_dt2); mul_b = w_acc; mul_hi = 1'b1; end
            S_Q1: begin mul_a = w_dt; mul_b = w_acc; end
            S_A: begin mul_a = w_dt; mul_b = OPW'(r_p01) + OPW'(r_p10); end
            S_B: begin mul_a = OPW'(r_dt2); mul_b = OPW'(r_p11); end
            S_C: begin mul_a = w_dt; mul_b = OPW'(r_p11); end
            S_D: begin mul_a = OPW'(r_vel); mul_b = w_dt; end
            S_E: begin mul_a = OPW'(r_k0); mul_b = OPW'(w_innov); end
            S_F: begin mul_a = OPW'(r_k1); mul_b = OPW'(w_innov); end
            S_G: begin mul_a = w_one_k0; mul_b = OPW'(r_m00); end
            S_H: begin mul_a = w_one_k0; mul_b = OPW'(r_m01); end
            S_I: begin mul_a = OPW'(r_k1); mul_b = OPW'(r_m00); end
            S_J: begin mul_a = OPW'(r_k1); mul_b = OPW'(r_m01); end
            default: begin end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;  n_issued = r_issued;
        n_pos = r_pos;  n_vel = r_vel;  n_xp = r_xp;  n_z = r_z;
        n_p00 = r_p00;  n_p01 = r_p01;  n_p10 = r_p10;  n_p11 = r_p11;
        n_dt2 = r_dt2;  n_q0 = r_q0;  n_q1 = r_q1;  n_a = r_a;
        n_m00 = r_m00;  n_m01 = r_m01;  n_m10 = r_m10;  n_m11 = r_m11;
        n_k0 = r_k0;  n_k1 = r_k1;
        n_opos = r_opos;  n_ovel = r_ovel;
        n_ovalid = r_ovalid && !o_est.ready;
        mul_start = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_meas.valid) begin
                    n_z     = i_meas.measurement;
                    n_state = S_DT2;
                end
            end
            S_K0, S_K1: begin
                if (!r_issued) begin
                    if (w_s_pos) begin
                        div_start = 1'b1;
                        n_issued  = 1'b1;
                    end else begin
                        n_k0    = '0;
                        n_k1    = '0;
                        n_state = S_D;
                    end
                end else if (div_done) begin
                    n_issued = 1'b0;
                    if (r_state == S_K0) begin
                        n_k0    = div_res;
                        n_state = S_K1;
                    end else begin
                        n_k1    = div_res;
                        n_state = S_D;
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid || o_est.ready) begin
                    n_ovalid = 1'b1;
                    n_opos   = r_pos;
                    n_ovel   = r_vel;
                    n_state  = S_IDLE;
                end
            end
            S_DT2, S_Q0, S_Q1, S_A, S_B, S_C, S_D, S_E, S_F, S_G, S_H, S_I, S_J: begin
                if (!r_issued) begin
                    mul_start = 1'b1;
                    n_issued  = 1'b1;
                end else if (mul_done) begin
                    n_issued = 1'b0;
                    unique case (r_state)
                        S_DT2: begin n_dt2 = mul_res; n_state = S_Q0; end
                        S_Q0: begin n_q0 = mul_res; n_state = S_Q1; end
                        S_Q1: begin n_q1 = mul_res; n_state = S_A; end
                        S_A: begin n_a = mul_res; n_state = S_B; end
                        S_B: begin
                            n_m00 = sat48(52'(r_p00) + 52'(r_a) + 52'(mul_res) + 52'(r_q0));
                            n_state = S_C;
                        end
                        S_C: begin
                            n_m01   = sat48(52'(r_p01) + 52'(mul_res));
                            n_m10   = sat48(52'(r_p10) + 52'(mul_res));
                            n_m11   = sat48(52'(r_p11) + 52'(r_q1));
                            n_state = S_K0;
                        end
                        S_D: begin n_xp = sat32(50'(r_pos) + 50'(mul_res)); n_state = S_E; end
                        S_E: begin n_pos = sat32(50'(r_xp) + 50'(mul_res)); n_state = S_F; end
                        S_F: begin n_vel = sat32(50'(r_vel) + 50'(mul_res)); n_state = S_G; end
                        S_G: begin n_p00 = mul_res; n_state = S_H; end
                        S_H: begin n_p01 = mul_res; n_state = S_I; end
                        S_I: begin n_p10 = sat48(52'(r_m10) - 52'(mul_res)); n_state = S_J; end
                        S_J: begin n_p11 = sat48(52'(r_m11) - 52'(mul_res)); n_state = S_OUT; end
                        default: begin end
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
            r_step   <= STEP_RST;
            r_accel  <= NOISE_RST;
            r_meas   <= NOISE_RST;
            r_pos    <= '0;
            r_vel    <= '0;
            r_p00    <= ONE_OP[COV_W-1:0];
            r_p01    <= '0;
            r_p10    <= '0;
            r_p11    <= ONE_OP[COV_W-1:0];
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            r_ovalid <= n_ovalid;
            r_pos    <= n_pos;
            r_vel    <= n_vel;
            r_p00    <= n_p00;
            r_p01    <= n_p01;
            r_p10    <= n_p10;
            r_p11    <= n_p11;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_STEP_TIME) r_step <= i_cfg_data[STEP_W-1:0];
                else if (i_cfg_idx == CFG_ACCEL_NOISE) r_accel <= i_cfg_data[NOISE_W-1:0];
                else if (i_cfg_idx == CFG_MEAS_NOISE) r_meas <= i_cfg_data[NOISE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_xp   <= n_xp;
        r_z    <= n_z;
        r_dt2  <= n_dt2;
        r_q0   <= n_q0;
        r_q1   <= n_q1;
        r_a    <= n_a;
        r_m00  <= n_m00;
        r_m01  <= n_m01;
        r_m10  <= n_m10;
        r_m11  <= n_m11;
        r_k0   <= n_k0;
        r_k1   <= n_k1;
        r_opos <= n_opos;
        r_ovel <= n_ovel;
    end

    assign i_meas.ready            = (r_state == S_IDLE);
    assign o_est.valid             = r_ovalid;
    assign o_est.position_estimate = r_opos;
    assign o_est.velocity_estimate = r_ovel;

    `KFPV_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_meas.valid && i_meas.ready, r_state == S_DT2, "transfer did not start the sequence")
    `KFPV_ASSERT_NOW(a_mul_done_issued, i_clk, i_rst_n, mul_done, r_issued, "product returned with no request open")
    `KFPV_ASSERT_NEXT(a_zero_gain, i_clk, i_rst_n, r_state == S_K0 && !r_issued && !w_s_pos, r_k0 == '0 && r_k1 == '0 && r_state == S_D, "non-positive innovation variance did not clear gains")

endmodule
